// ===== rtl/kmrb_pkg.sv =====
// ----------------------------------------------------------------------------
// kmrb_pkg
// Shared types and constants of the key matrix report builder.
// ----------------------------------------------------------------------------
package kmrb_pkg;

    // Matrix geometry and report size
    localparam int ROWS         = 2;   // 1..2
    localparam int COLS         = 4;   // 1..4
    localparam int REPORT_SLOTS = 6;   // 1..8
    localparam int OUT_SLOTS    = 6;   // slots carried in the report
    localparam int MAP_STRIDE   = 4;   // keymap bytes per row
    localparam int MAP_ROWS     = 2;   // rows carried in the poll

    localparam int SLOT_LIMIT = (REPORT_SLOTS < OUT_SLOTS) ? REPORT_SLOTS : OUT_SLOTS;
    localparam int CNT_W      = $clog2(OUT_SLOTS + 1);
    localparam int SLOT_IDX_W = $clog2(OUT_SLOTS);

    // Configuration space
    localparam int           PADDR_W      = 4;
    localparam int           REG_IDX_BIT  = 3;
    localparam logic [63:0]  KEYMAP_RESET = 64'h0706_0504_2120_1F1E;

    typedef enum logic [1:0] {
        KIND_KEYS    = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_WAKEUP  = 2'd2
    } report_kind_t;

    typedef struct packed {
        logic [3:0] row0_levels;
        logic [3:0] row1_levels;
        logic       hid_ready;
        logic       bus_suspended;
        logic       button_level;
    } poll_t;

    typedef struct packed {
        logic [1:0] report_kind;
        logic [7:0] key_slot0;
        logic [7:0] key_slot1;
        logic [7:0] key_slot2;
        logic [7:0] key_slot3;
        logic [7:0] key_slot4;
        logic [7:0] key_slot5;
    } report_t;

    // Packer status towards the report decision
    typedef struct packed {
        logic                          any_key;
        logic [OUT_SLOTS-1:0][7:0]     slots;
    } pack_result_t;

endpackage

// ===== rtl/key_matrix_report_builder_core.sv =====
// ----------------------------------------------------------------------------
// key_matrix_report_builder_core
// Turns matrix polls into 6-key boot keyboard reports and wakeup requests.
// ----------------------------------------------------------------------------
// Usage:
//  - poll channel (poll_valid / poll_stall / poll): one matrix poll per
//    transfer, with both rows' active-low column levels and the ready,
//    suspend and button flags.
//  - report channel (report_valid / report_stall / report): zero or one
//    report per poll: key report, empty release report or remote wakeup.
//  - APB port: one 64-bit keymap register at byte address 0, byte r*4+c
//    holds the keycode of row r column c. Write only while idle.
// Timing:
//  - a poll is registered on transfer and decoded from the poll register; its
//    report is then loaded into the report register, which drives
//    report_valid.
//  - one poll per cycle sustained while the report channel does not stall;
//    the decode is a single pass between the poll register and the report register.
//  - a poll that yields no report (not ready, or nothing owed) is dropped.
// Reset: both stages empty, keymap at its default, and an empty release
//  report owed, so the first idle ready poll produces one.
// Stall: a stalled report holds; the decode stage then holds its poll and
//  poll_stall rises while that stage is occupied and cannot advance.
// ----------------------------------------------------------------------------
module key_matrix_report_builder_core
    import kmrb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               poll_valid,
    output logic               poll_stall,
    input  poll_t              poll,

    output logic               report_valid,
    input  logic               report_stall,
    output report_t            report,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    logic [63:0]  keymap;

    // poll register
    logic         poll_valid_reg;
    poll_t        poll_reg;

    // report register
    logic         report_valid_reg;
    report_t      report_reg;

    // empty report owed
    logic         release_pending_reg;
    logic         release_pending_next;

    logic         stage_move;
    logic         has_report;
    report_t      report_next;
    pack_result_t pack;

    logic [MAP_ROWS-1:0][3:0] levels;

    kmrb_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .keymap  (keymap)
    );

    assign levels[0] = poll_reg.row0_levels;
    assign levels[1] = poll_reg.row1_levels;

    kmrb_slot_packer u_slot_packer (
        .levels (levels),
        .keymap (keymap),
        .result (pack)
    );

    // the decode stage advances whenever the report register is free or being taken
    assign stage_move = !report_valid_reg || !report_stall;
    // an empty poll register always takes a transfer
    assign poll_stall = poll_valid_reg && !stage_move;

    // report decision: wakeup beats scan, scan needs ready, release is sent once
    always_comb
    begin
        report_next           = '0;
        has_report            = 1'b0;
        release_pending_next  = release_pending_reg;
        if (poll_reg.bus_suspended && poll_reg.button_level)
        begin
            has_report              = 1'b1;
            report_next.report_kind = KIND_WAKEUP;
        end
        else if (poll_reg.hid_ready)
        begin
            if (pack.any_key)
            begin
                has_report              = 1'b1;
                report_next.report_kind = KIND_KEYS;
                report_next.key_slot0   = pack.slots[0];
                report_next.key_slot1   = pack.slots[1];
                report_next.key_slot2   = pack.slots[2];
                report_next.key_slot3   = pack.slots[3];
                report_next.key_slot4   = pack.slots[4];
                report_next.key_slot5   = pack.slots[5];
                release_pending_next    = 1'b1;
            end
            else if (release_pending_reg)
            begin
                has_report              = 1'b1;
                report_next.report_kind = KIND_RELEASE;
                release_pending_next    = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid_reg      <= 1'b0;
            report_valid_reg    <= 1'b0;
            release_pending_reg <= 1'b1;
        end
        else
        begin
            if (!poll_stall)
            begin
                poll_valid_reg <= poll_valid;
            end
            if (stage_move)
            begin
                report_valid_reg <= poll_valid_reg && has_report;
                if (poll_valid_reg)
                begin
                    release_pending_reg <= release_pending_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!poll_stall && poll_valid)
        begin
            poll_reg <= poll;
        end
        if (stage_move && poll_valid_reg && has_report)
        begin
            report_reg <= report_next;
        end
    end

    assign report_valid = report_valid_reg;
    assign report       = report_reg;

endmodule

// ===== rtl/kmrb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// kmrb_cfg_regs
// APB register file holding the 64-bit keymap.
// ----------------------------------------------------------------------------
module kmrb_cfg_regs
    import kmrb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    output logic [63:0]        keymap
);

    logic [63:0] keymap_reg;
    logic [63:0] keymap_next;
    logic        sel_keymap;

    // register index sits in paddr[3]; low bits are byte offsets
    assign sel_keymap = (paddr[REG_IDX_BIT] == 1'b0);

    always_comb
    begin
        keymap_next = keymap_reg;
        if (psel && penable && pwrite && sel_keymap)
        begin
            keymap_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keymap_reg <= KEYMAP_RESET;
        end
        else
        begin
            keymap_reg <= keymap_next;
        end
    end

    assign prdata = sel_keymap ? keymap_reg : 64'd0;
    assign pready = 1'b1;
    assign keymap = keymap_reg;

endmodule

// ===== rtl/kmrb_slot_packer.sv =====
// ----------------------------------------------------------------------------
// kmrb_slot_packer
// Scans the matrix in row-major order and packs pressed keycodes into slots.
// ----------------------------------------------------------------------------
module kmrb_slot_packer
    import kmrb_pkg::*;
(
    input  logic [MAP_ROWS-1:0][3:0] levels,
    input  logic [63:0]              keymap,
    output pack_result_t             result
);

    logic [OUT_SLOTS-1:0][7:0] slots;
    logic [CNT_W-1:0]          taken;
    logic                      any_key;

    always_comb
    begin
        slots   = '0;
        taken   = '0;
        any_key = 1'b0;
        for (int r = 0; r < ROWS; r++)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                if (!levels[r][c])
                begin
                    any_key = 1'b1;
                    if (taken < CNT_W'(SLOT_LIMIT))
                    begin
                        slots[taken[SLOT_IDX_W-1:0]] = keymap[8*(r*MAP_STRIDE+c) +: 8];
                        taken = taken + 1'b1;
                    end
                end
            end
        end
    end

    assign result.any_key = any_key;
    assign result.slots   = slots;

endmodule
